FILE: sv/s337_pkg.sv
// Shared types and constants for the SMPTE 337M AC-3 burst extractor.
package s337_pkg;

    // Preamble words and data type code
    localparam logic [7:0]  SYNC_PA_HI    = 8'hf8;
    localparam logic [7:0]  SYNC_PA_LO    = 8'h72;
    localparam logic [7:0]  SYNC_PB_HI    = 8'h4e;
    localparam logic [7:0]  SYNC_PB_LO    = 8'h1f;
    localparam logic [4:0]  DATA_TYPE_AC3 = 5'd1;

    // Configuration register map
    localparam int          PADDR_W       = 3;
    localparam logic [PADDR_W-1:0] ADDR_BURSTS_PER_GROUP = 3'd0;
    localparam logic [7:0]  BPG_RESET     = 8'd1;

    // Input transaction
    typedef struct packed {
        logic [15:0] left_word;
        logic [15:0] right_word;
    } in_t;

    // Result transaction
    typedef struct packed {
        logic [31:0] payload_word;
        logic [2:0]  byte_count;
        logic        burst_end;
        logic        group_end;
    } out_t;

    // Queue entry: unmasked word plus byte count and end flags
    typedef struct packed {
        logic [31:0] raw_word;
        logic [2:0]  byte_count;
        logic        burst_end;
        logic        group_end;
    } cmd_t;

    // Front to back push
    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } q_push_t;

    // Parser modes, one-hot
    typedef enum logic [2:0] {
        MODE_SEARCH  = 3'b001,
        MODE_HEADER  = 3'b010,
        MODE_PAYLOAD = 3'b100
    } mode_t;

endpackage

FILE: sv/smpte337_ac3_burst_extractor.sv
// Top level: SMPTE 337M AC-3 burst extractor with APB configuration port.
// Takes one 16-bit stereo sample pair per transaction and can accept a new pair
// every cycle while the queue is not full; each pair is parsed in the cycle it
// is accepted, and any result is registered into a QUEUE_DEPTH-entry queue whose
// head drives the output. Input ready drops only while the queue is full.
// Register 0 at address 0, bursts_per_group (8 bits, reset 1), sets how many
// bursts form a group; write it only while the block is idle.
module smpte337_ac3_burst_extractor #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [s337_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    // sample pair input
    input  logic                          in_valid,
    output logic                          in_ready,
    input  s337_pkg::in_t                 in_data,
    // result output
    output logic                          out_valid,
    input  logic                          out_ready,
    output s337_pkg::out_t                out_data
);
    import s337_pkg::*;

    logic [7:0] bpg_reg;
    logic       q_full;
    q_push_t    q_push;

    // Configuration register
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            bpg_reg <= BPG_RESET;
        else if (psel && penable && pwrite && (paddr == ADDR_BURSTS_PER_GROUP))
            bpg_reg <= pwdata[7:0];
    end

    assign prdata = (paddr == ADDR_BURSTS_PER_GROUP) ? {24'd0, bpg_reg} : 32'd0;

    // Parser
    s337_front u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .in_data          (in_data),
        .bursts_per_group (bpg_reg),
        .q_full           (q_full),
        .q_push           (q_push)
    );

    // Result queue and output
    s337_back #(
        .DEPTH (QUEUE_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_push    (q_push),
        .q_full    (q_full),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

FILE: sv/s337_front.sv
// Front end: accepts sample pairs, tracks sync/header/payload, queues results.
module s337_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  s337_pkg::in_t   in_data,
    input  logic [7:0]      bursts_per_group,
    input  logic            q_full,
    output s337_pkg::q_push_t q_push
);
    import s337_pkg::*;

    mode_t       mode_reg, mode_next;
    logic [12:0] bytes_left_reg, bytes_left_next;
    logic [7:0]  burst_count_reg, burst_count_next;

    logic        accept;
    logic        is_preamble;
    logic [7:0]  count_inc;
    logic        group_hit;
    logic [12:0] hdr_len;
    logic [2:0]  take_n;
    logic [12:0] left_after;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    assign is_preamble = (in_data.left_word  == {SYNC_PA_HI, SYNC_PA_LO}) &&
                         (in_data.right_word == {SYNC_PB_HI, SYNC_PB_LO});

    // Burst counting
    assign count_inc = burst_count_reg + 8'd1;
    assign group_hit = (count_inc == bursts_per_group);

    assign hdr_len    = in_data.right_word[15:3];
    assign take_n     = (bytes_left_reg >= 13'd4) ? 3'd4 : bytes_left_reg[2:0];
    assign left_after = bytes_left_reg - {10'd0, take_n};

    // Parser next state and result push
    always_comb
    begin
        mode_next        = mode_reg;
        bytes_left_next  = bytes_left_reg;
        burst_count_next = burst_count_reg;
        q_push           = '0;
        if (accept)
        begin
            unique case (mode_reg)
                MODE_HEADER:
                begin
                    if (in_data.left_word[4:0] == DATA_TYPE_AC3)
                    begin
                        if (hdr_len == 13'd0)
                        begin
                            // empty burst: one bare end marker
                            q_push.valid          = 1'b1;
                            q_push.cmd.burst_end  = 1'b1;
                            q_push.cmd.group_end  = group_hit;
                            mode_next             = MODE_SEARCH;
                            bytes_left_next       = 13'd0;
                            burst_count_next      = group_hit ? 8'd0 : count_inc;
                        end
                        else
                        begin
                            bytes_left_next = hdr_len;
                            mode_next       = MODE_PAYLOAD;
                        end
                    end
                    else
                    begin
                        mode_next = is_preamble ? MODE_HEADER : MODE_SEARCH;
                    end
                end
                MODE_PAYLOAD:
                begin
                    q_push.valid          = 1'b1;
                    q_push.cmd.raw_word   = {in_data.left_word, in_data.right_word};
                    q_push.cmd.byte_count = take_n;
                    bytes_left_next       = left_after;
                    if (left_after == 13'd0)
                    begin
                        q_push.cmd.burst_end = 1'b1;
                        q_push.cmd.group_end = group_hit;
                        mode_next            = MODE_SEARCH;
                        burst_count_next     = group_hit ? 8'd0 : count_inc;
                    end
                end
                default:
                begin
                    mode_next = is_preamble ? MODE_HEADER : MODE_SEARCH;
                end
            endcase
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= MODE_SEARCH;
            bytes_left_reg  <= '0;
            burst_count_reg <= '0;
        end
        else
        begin
            mode_reg        <= mode_next;
            bytes_left_reg  <= bytes_left_next;
            burst_count_reg <= burst_count_next;
        end
    end

endmodule

FILE: sv/s337_back.sv
// Back end: result queue, byte masking and output handshake.
module s337_back #(
    parameter int DEPTH = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  s337_pkg::q_push_t q_push,
    output logic              q_full,
    output logic              out_valid,
    input  logic              out_ready,
    output s337_pkg::out_t    out_data
);
    import s337_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    cmd_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    logic             push;
    logic             pop;
    cmd_t             head;
    logic [31:0]      keep_mask;

    assign push      = q_push.valid && !q_full;
    assign out_valid = (cnt_reg != '0);
    assign pop       = out_valid && out_ready;
    assign q_full    = (cnt_reg == FULL_CNT);

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (push && !pop)
            cnt_next = cnt_reg + CNT_W'(1);
        else if (pop && !push)
            cnt_next = cnt_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Queue storage, no reset on payload
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= q_push.cmd;
    end

    assign head = entry_reg[rd_ptr_reg];

    // Keep only the valid leading bytes
    always_comb
    begin
        unique case (head.byte_count)
            3'd0:    keep_mask = 32'h0000_0000;
            3'd1:    keep_mask = 32'hff00_0000;
            3'd2:    keep_mask = 32'hffff_0000;
            3'd3:    keep_mask = 32'hffff_ff00;
            default: keep_mask = 32'hffff_ffff;
        endcase
    end

    assign out_data.payload_word = head.raw_word & keep_mask;
    assign out_data.byte_count   = head.byte_count;
    assign out_data.burst_end    = head.burst_end;
    assign out_data.group_end    = head.group_end;

endmodule
